>>> src/assert_macros.svh
// Assertion macros for the RTL of the stress core.
// Clocked by clk_i; the checked form is dropped when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// check a property at every clock edge outside reset
`define HPK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// check a property at every clock edge, reset included
`define HPK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define HPK_ASSERT(lbl, prop, msg)
`define HPK_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> src/hpk_pkg.sv
// Shared widths, codes and helpers of the PK2 stress core.
// No dependencies; used by hpk_div, the core top level and the testbench.
package hpk_pkg;

  // field widths
  localparam int unsigned FW  = 32;  // deformation gradient entry, Q4.28
  localparam int unsigned SW  = 48;  // stress entry, Q20.28
  localparam int unsigned CW  = 38;  // right Cauchy-Green entry
  localparam int unsigned MNW = 37;  // 2x2 minor of F
  localparam int unsigned EW  = 39;  // doubled strain entry
  localparam int unsigned TRW = 41;  // strain trace
  localparam int unsigned LW  = 59;  // rounded linear/SVK stress
  localparam int unsigned JW  = 44;  // rounded determinant
  localparam int unsigned AW  = 50;  // rounded adjugate entry
  localparam int unsigned KW  = 60;  // rounded Neo-Hookean factor
  localparam int unsigned PW  = 104; // numerator of the final quotient
  localparam int unsigned QB  = 49;  // quotient bits kept before clamping
  localparam int unsigned MW  = PW + 2;

  // register indexes
  localparam logic [1:0] REG_MODEL  = 2'd0;
  localparam logic [1:0] REG_LAMBDA = 2'd1;
  localparam logic [1:0] REG_SHEAR  = 2'd2;
  localparam logic [1:0] REG_NONE   = 2'd3;

  // material model codes
  localparam logic [1:0] MODEL_LIN    = 2'd0;
  localparam logic [1:0] MODEL_SVK    = 2'd1;
  localparam logic [1:0] MODEL_NEO    = 2'd2;
  localparam logic [1:0] MODEL_UNUSED = 2'd3;

  // symmetric entry order: xx yy zz xy xz yz
  localparam int unsigned ENT_ROW [6] = '{0, 1, 2, 0, 0, 1};
  localparam int unsigned ENT_COL [6] = '{0, 1, 2, 1, 2, 2};

  // adjugate entry k = c[ADJ_A0]*c[ADJ_A1] - c[ADJ_B0]*c[ADJ_B1], c in entry order
  localparam int unsigned ADJ_A0 [6] = '{1, 0, 0, 4, 3, 3};
  localparam int unsigned ADJ_A1 [6] = '{2, 2, 1, 5, 5, 4};
  localparam int unsigned ADJ_B0 [6] = '{5, 4, 3, 3, 4, 0};
  localparam int unsigned ADJ_B1 [6] = '{5, 4, 3, 2, 1, 5};

  typedef struct packed {
    logic            clip;
    logic [SW-1:0]   val;
  } sat_t;

  // clip a wide stress to the 48-bit output range
  function automatic sat_t sat48(input logic signed [63:0] x);
    sat_t r;
    if (x > 64'sd140737488355327) begin
      r.clip = 1'b1;
      r.val  = 48'h7FFF_FFFF_FFFF;
    end else if (x < -64'sd140737488355328) begin
      r.clip = 1'b1;
      r.val  = 48'h8000_0000_0000;
    end else begin
      r.clip = 1'b0;
      r.val  = x[SW-1:0];
    end
    return r;
  endfunction

endpackage

>>> src/hpk_wmul.sv
// Two-stage signed 64x64 multiplier built from four partial products of 33-bit and 32-bit words.
// Depends on nothing; instantiated by the stress core.
module hpk_wmul (
  input  logic                clk_i,
  input  logic signed [63:0]  a_i,
  input  logic signed [63:0]  b_i,
  output logic signed [127:0] p_o
);

  logic signed [32:0]  a_lo, b_lo;
  logic signed [31:0]  a_hi, b_hi;
  logic signed [65:0]  ll_q;
  logic signed [64:0]  lh_q, hl_q;
  logic signed [63:0]  hh_q;
  logic signed [127:0] p_d;

  // split each operand into an unsigned low word and a signed high word
  always_comb begin
    a_lo = $signed({1'b0, a_i[31:0]});
    b_lo = $signed({1'b0, b_i[31:0]});
    a_hi = a_i[63:32];
    b_hi = b_i[63:32];
  end

  // stage 1: partial products
  always_ff @(posedge clk_i) begin
    ll_q <= a_lo * b_lo;
    lh_q <= a_lo * b_hi;
    hl_q <= a_hi * b_lo;
    hh_q <= a_hi * b_hi;
  end

  // stage 2: weight and add the partials
  always_comb begin
    p_d = 128'(ll_q) + (128'(lh_q) <<< 32) + (128'(hl_q) <<< 32) + (128'(hh_q) <<< 64);
  end

  always_ff @(posedge clk_i) begin
    p_o <= p_d;
  end

endmodule

>>> src/hpk_delay.sv
// Plain shift line that delays a payload vector by a fixed number of cycles.
// Depends on nothing; used to align side data with the long arithmetic paths.
module hpk_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  // advance every tap each cycle
  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int k = 1; k < N; k++) begin
      sr_q[k] <= sr_q[k-1];
    end
  end

  assign q_o = sr_q[N-1];

endmodule

>>> src/hpk_div.sv
// Pipelined restoring divider, one quotient bit per stage, rounding ties away from zero.
// Depends on hpk_pkg; quotients at or above 2^QB come out clamped to all ones.
module hpk_div
  import hpk_pkg::*;
(
  input  logic                 clk_i,
  input  logic signed [PW-1:0] num_i,
  input  logic signed [JW-1:0] den_i,
  output logic [QB-1:0]        quo_o,
  output logic                 neg_o
);

  localparam int unsigned RW = JW + 1;
  localparam int unsigned UW = MW - QB;

  logic [PW-1:0] mag_n;
  logic [JW-1:0] mag_d;
  logic [MW-1:0] m_full;
  logic [RW-1:0] dv;
  logic          ovf;

  logic [RW-1:0] r_q   [QB];
  logic [QB-1:0] low_q [QB];
  logic [RW-1:0] dv_q  [QB];
  logic          neg_q [QB+1];
  logic          ovf_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];

  logic [RW:0]   rs_w  [QB];
  logic [RW-1:0] r_d   [QB];
  logic          bit_d [QB];

  // form 2|n| + |d| over 2|d| and check for a quotient beyond QB bits
  always_comb begin
    mag_n  = num_i[PW-1] ? PW'(-num_i) : PW'(num_i);
    mag_d  = den_i[JW-1] ? JW'(-den_i) : JW'(den_i);
    m_full = {mag_n, 1'b0} + MW'(mag_d);
    dv     = {mag_d, 1'b0};
    ovf    = m_full[MW-1:QB] >= UW'(dv);
  end

  // one trial subtraction per stage
  always_comb begin
    for (int k = 0; k < QB; k++) begin
      rs_w[k] = {r_q[k], low_q[k][QB-1]};
      bit_d[k] = rs_w[k] >= {1'b0, dv_q[k]};
      if (bit_d[k]) begin
        r_d[k] = RW'(rs_w[k] - {1'b0, dv_q[k]});
      end else begin
        r_d[k] = RW'(rs_w[k]);
      end
    end
  end

  // advance the stages
  always_ff @(posedge clk_i) begin
    r_q[0]   <= m_full[QB+RW-1:QB];
    low_q[0] <= m_full[QB-1:0];
    dv_q[0]  <= dv;
    neg_q[0] <= num_i[PW-1] ^ den_i[JW-1];
    ovf_q[0] <= ovf;
    quo_q[0] <= '0;
    for (int k = 0; k < QB; k++) begin
      if (k < QB - 1) begin
        r_q[k+1]   <= r_d[k];
        low_q[k+1] <= {low_q[k][QB-2:0], 1'b0};
        dv_q[k+1]  <= dv_q[k];
      end
      neg_q[k+1] <= neg_q[k];
      ovf_q[k+1] <= ovf_q[k];
      quo_q[k+1] <= {quo_q[k][QB-2:0], bit_d[k]};
    end
  end

  assign quo_o = ovf_q[QB] ? '1 : quo_q[QB];
  assign neg_o = neg_q[QB];

endmodule

>>> src/hyperelastic_pk2_stress_core.sv
// Second Piola-Kirchhoff stress core: top level with config registers and the pipeline.
// Depends on hpk_pkg, hpk_wmul, hpk_delay, hpk_div and assert_macros.svh.
//
// One deformation gradient is taken on every cycle that start_i is high (busy_o is
// always low), and its six stress entries appear with done_o at the pipeline's end,
// one result per item in order. The latency is set by the 49-stage quotient pipeline
// of the Neo-Hookean path behind twelve stages of products, sums and roundings; all
// three material models run through the same depth. The results cannot be held off,
// so the consumer must take done_o whenever it rises. Configuration is written over
// the cfg_* port (always ready) and must only change while no item is in flight.
`include "assert_macros.svh"

module hyperelastic_pk2_stress_core
  import hpk_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic signed [FW-1:0] f_xx_i,
  input  logic signed [FW-1:0] f_xy_i,
  input  logic signed [FW-1:0] f_xz_i,
  input  logic signed [FW-1:0] f_yx_i,
  input  logic signed [FW-1:0] f_yy_i,
  input  logic signed [FW-1:0] f_yz_i,
  input  logic signed [FW-1:0] f_zx_i,
  input  logic signed [FW-1:0] f_zy_i,
  input  logic signed [FW-1:0] f_zz_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 done_o,
  output logic signed [SW-1:0] s_xx_o,
  output logic signed [SW-1:0] s_yy_o,
  output logic signed [SW-1:0] s_zz_o,
  output logic signed [SW-1:0] s_xy_o,
  output logic signed [SW-1:0] s_xz_o,
  output logic signed [SW-1:0] s_yz_o,
  output logic                 singular_o,
  output logic                 saturated_o
);

  localparam int unsigned T_DIV = 12 + QB + 1;
  localparam int unsigned LAT   = T_DIV + 1;
  localparam int unsigned NWM   = 22;

  // configuration
  logic [1:0]  material_model_q;
  logic [31:0] lambda_q, shear_q;
  logic signed [32:0] lam_s, g_s;

  logic [LAT:1] vld_q;

  // pipeline payload
  logic signed [FW-1:0]  f1_q [9], f2_q [9], f3_q [9];
  logic signed [FW-1:0]  f04_q [3];
  logic signed [63:0]    cp_d [6][3], cp2_q [6][3];
  logic signed [63:0]    mp_d [3][2], mp2_q [3][2];
  logic signed [65:0]    csum [6], msum [3];
  logic signed [CW-1:0]  c3_q [6], c4_q [6];
  logic signed [MNW-1:0] m3_q [3], m4_q [3];
  logic signed [EW-1:0]  e4_d [6], e4_q [6];
  logic signed [TRW-1:0] tr4_d, tr4_q;

  logic signed [63:0]    wa [NWM], wb [NWM];
  logic signed [127:0]   wp [NWM];

  logic signed [79:0]    lsum [6], asum [6];
  logic signed [71:0]    dsum;
  logic signed [LW-1:0]  lin7_q [6];
  logic signed [JW-1:0]  jq7_d, jq7_q;
  logic                  sing7_q;
  logic signed [AW-1:0]  adj7_q [6];

  logic signed [63:0]    kb;
  logic signed [127:0]   kkp;
  logic signed [79:0]    ksum;
  logic signed [KW-1:0]  kq10_q;
  logic [6*AW-1:0]       adj_flat, adj_dly;
  logic signed [127:0]   kp [6];
  logic [JW-1:0]         jq12;

  logic [6*LW:0]         lin_flat, lin_dly;
  logic [QB-1:0]         dq [6];
  logic                  dneg [6];

  logic signed [63:0]    qs [6], neo [6], lin [6];
  sat_t                  st_neo [6], st_lin [6];
  logic [SW-1:0]         s_d [6];
  logic                  sing_d, sat_d;
  logic [SW-1:0]         s_q [6];
  logic                  sing_q, sat_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign lam_s       = $signed({1'b0, lambda_q});
  assign g_s         = $signed({1'b0, shear_q});

  // hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      material_model_q <= MODEL_LIN;
      lambda_q         <= 32'd65536;
      shear_q          <= 32'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MODEL:  material_model_q <= cfg_data_i[1:0];
        REG_LAMBDA: lambda_q         <= cfg_data_i;
        REG_SHEAR:  shear_q          <= cfg_data_i;
        REG_NONE:   ;
        default:    ;
      endcase
    end
  end

  // advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-1:1], start_i & ~busy_o};
    end
  end

  // stage 1: capture the gradient
  always_ff @(posedge clk_i) begin
    f1_q[0] <= f_xx_i; f1_q[1] <= f_xy_i; f1_q[2] <= f_xz_i;
    f1_q[3] <= f_yx_i; f1_q[4] <= f_yy_i; f1_q[5] <= f_yz_i;
    f1_q[6] <= f_zx_i; f1_q[7] <= f_zy_i; f1_q[8] <= f_zz_i;
  end

  // stage 2: products for F^T F and the row-0 minors
  always_comb begin
    for (int e = 0; e < 6; e++) begin
      for (int k = 0; k < 3; k++) begin
        cp_d[e][k] = f1_q[k*3 + ENT_ROW[e]] * f1_q[k*3 + ENT_COL[e]];
      end
    end
    mp_d[0][0] = f1_q[4] * f1_q[8]; mp_d[0][1] = f1_q[5] * f1_q[7];
    mp_d[1][0] = f1_q[3] * f1_q[8]; mp_d[1][1] = f1_q[5] * f1_q[6];
    mp_d[2][0] = f1_q[3] * f1_q[7]; mp_d[2][1] = f1_q[4] * f1_q[6];
  end

  always_ff @(posedge clk_i) begin
    cp2_q <= cp_d;
    mp2_q <= mp_d;
    f2_q  <= f1_q;
  end

  // stage 3: sum and round C and the minors to Q.28
  always_comb begin
    for (int e = 0; e < 6; e++) begin
      csum[e] = 66'(cp2_q[e][0]) + 66'(cp2_q[e][1]) + 66'(cp2_q[e][2]) + 66'sd134217728;
    end
    for (int n = 0; n < 3; n++) begin
      msum[n] = 66'(mp2_q[n][0]) - 66'(mp2_q[n][1]) + 66'sd134217728;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < 6; e++) begin
      c3_q[e] <= CW'(csum[e] >>> 28);
    end
    for (int n = 0; n < 3; n++) begin
      m3_q[n] <= MNW'(msum[n] >>> 28);
    end
    f3_q <= f2_q;
  end

  // stage 4: doubled strain and its trace
  always_comb begin
    for (int e = 0; e < 6; e++) begin
      if (material_model_q == MODEL_LIN) begin
        e4_d[e] = EW'(f3_q[ENT_ROW[e]*3 + ENT_COL[e]]) + EW'(f3_q[ENT_COL[e]*3 + ENT_ROW[e]])
                - ((e < 3) ? 39'sd536870912 : 39'sd0);
      end else begin
        e4_d[e] = EW'(c3_q[e]) - ((e < 3) ? 39'sd268435456 : 39'sd0);
      end
    end
    tr4_d = TRW'(e4_d[0]) + TRW'(e4_d[1]) + TRW'(e4_d[2]);
  end

  always_ff @(posedge clk_i) begin
    e4_q  <= e4_d;
    tr4_q <= tr4_d;
    c4_q  <= c3_q;
    m4_q  <= m3_q;
    for (int k = 0; k < 3; k++) begin
      f04_q[k] <= f3_q[k];
    end
  end

  // stages 5-6: determinant terms, linear stress terms, adjugate products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wa[k] = 64'(f04_q[k]);
      wb[k] = 64'(m4_q[k]);
    end
    for (int e = 0; e < 6; e++) begin
      wa[3+e] = 64'(g_s);
      wb[3+e] = 64'(e4_q[e]);
    end
    wa[9] = 64'(lam_s);
    wb[9] = 64'(tr4_q);
    for (int a = 0; a < 6; a++) begin
      wa[10+2*a] = 64'(c4_q[ADJ_A0[a]]);
      wb[10+2*a] = 64'(c4_q[ADJ_A1[a]]);
      wa[11+2*a] = 64'(c4_q[ADJ_B0[a]]);
      wb[11+2*a] = 64'(c4_q[ADJ_B1[a]]);
    end
  end

  for (genvar w = 0; w < NWM; w++) begin : g_mul_a
    hpk_wmul u_mul (
      .clk_i (clk_i),
      .a_i   (wa[w]),
      .b_i   (wb[w]),
      .p_o   (wp[w])
    );
  end

  // stage 7: round linear stresses, determinant and adjugate
  always_comb begin
    for (int e = 0; e < 6; e++) begin
      lsum[e] = (80'(wp[3+e]) <<< 1) + ((e < 3) ? 80'(wp[9]) : 80'sd0) + 80'sd65536;
      asum[e] = 80'(wp[10+2*e]) - 80'(wp[11+2*e]) + 80'sd134217728;
    end
    dsum  = 72'(wp[0]) - 72'(wp[1]) + 72'(wp[2]) + 72'sd134217728;
    jq7_d = JW'(dsum >>> 28);
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < 6; e++) begin
      lin7_q[e] <= LW'(lsum[e] >>> 17);
      adj7_q[e] <= AW'(asum[e] >>> 28);
    end
    jq7_q   <= jq7_d;
    sing7_q <= (jq7_d == '0);
  end

  // stages 8-9: lambda (J - 1)
  assign kb = 64'(jq7_q) - 64'sd268435456;

  hpk_wmul u_mul_k (
    .clk_i (clk_i),
    .a_i   (64'(lam_s)),
    .b_i   (kb),
    .p_o   (kkp)
  );

  // stage 10: subtract G and round the factor
  assign ksum = 80'(kkp) - (80'(g_s) <<< 28) + 80'sd32768;

  always_ff @(posedge clk_i) begin
    kq10_q <= KW'(ksum >>> 16);
  end

  always_comb begin
    for (int a = 0; a < 6; a++) begin
      adj_flat[a*AW +: AW] = adj7_q[a];
    end
  end

  hpk_delay #(.W(6*AW), .N(3)) u_dly_adj (
    .clk_i (clk_i),
    .d_i   (adj_flat),
    .q_o   (adj_dly)
  );

  hpk_delay #(.W(JW), .N(5)) u_dly_jq (
    .clk_i (clk_i),
    .d_i   (jq7_q),
    .q_o   (jq12)
  );

  // stages 11-12: factor times adjugate; then the quotient pipelines
  for (genvar a = 0; a < 6; a++) begin : g_lane
    hpk_wmul u_mul_n (
      .clk_i (clk_i),
      .a_i   (64'(kq10_q)),
      .b_i   (64'($signed(adj_dly[a*AW +: AW]))),
      .p_o   (kp[a])
    );

    hpk_div u_div (
      .clk_i (clk_i),
      .num_i ($signed(kp[a][PW-1:0])),
      .den_i ($signed(jq12)),
      .quo_o (dq[a]),
      .neg_o (dneg[a])
    );
  end

  // carry linear results and the singular flag alongside the quotient pipelines
  always_comb begin
    for (int e = 0; e < 6; e++) begin
      lin_flat[e*LW +: LW] = lin7_q[e];
    end
    lin_flat[6*LW] = sing7_q;
  end

  hpk_delay #(.W(6*LW+1), .N(T_DIV-7)) u_dly_lin (
    .clk_i (clk_i),
    .d_i   (lin_flat),
    .q_o   (lin_dly)
  );

  // final stage: sign, add G on the diagonal, saturate, select the model
  always_comb begin
    sat_d  = 1'b0;
    sing_d = 1'b0;
    for (int e = 0; e < 6; e++) begin
      qs[e]  = dneg[e] ? -$signed({15'b0, dq[e]}) : $signed({15'b0, dq[e]});
      neo[e] = qs[e] + ((e < 3) ? (64'(g_s) <<< 12) : 64'sd0);
      lin[e] = 64'($signed(lin_dly[e*LW +: LW]));
      st_neo[e] = sat48(neo[e]);
      st_lin[e] = sat48(lin[e]);
      s_d[e]    = '0;
    end
    unique case (material_model_q)
      MODEL_LIN, MODEL_SVK: begin
        for (int e = 0; e < 6; e++) begin
          s_d[e] = st_lin[e].val;
          sat_d  = sat_d | st_lin[e].clip;
        end
      end
      MODEL_NEO: begin
        sing_d = lin_dly[6*LW];
        if (!sing_d) begin
          for (int e = 0; e < 6; e++) begin
            s_d[e] = st_neo[e].val;
            sat_d  = sat_d | st_neo[e].clip;
          end
        end
      end
      MODEL_UNUSED: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    sing_q <= sing_d;
    sat_q  <= sat_d;
  end

  assign done_o      = vld_q[LAT];
  assign s_xx_o      = s_q[0];
  assign s_yy_o      = s_q[1];
  assign s_zz_o      = s_q[2];
  assign s_xy_o      = s_q[3];
  assign s_xz_o      = s_q[4];
  assign s_yz_o      = s_q[5];
  assign singular_o  = sing_q;
  assign saturated_o = sat_q;

  // checks
  `HPK_ASSERT(a_sing_no_sat, done_o |-> !(singular_o && saturated_o), "singular result also flagged saturated")
  `HPK_ASSERT(a_sing_zero, done_o && singular_o |-> (s_xx_o == '0) && (s_yy_o == '0) && (s_zz_o == '0) && (s_xy_o == '0) && (s_xz_o == '0) && (s_yz_o == '0), "singular result carries nonzero stress")
  `HPK_ASSERT(a_sing_mode, done_o && singular_o |-> material_model_q == MODEL_NEO, "singular flag outside Neo-Hookean mode")
  `HPK_ASSERT(a_latency, done_o |-> $past(start_i, LAT), "result without a transfer at the pipeline depth")
  `HPK_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !done_o, "result strobe during reset")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for hyperelastic_pk2_stress_core: directed table, then random phases.
// Depends on hpk_pkg and the core RTL; stress is predicted in the bench in fixed point.
`timescale 1ns / 1ps

module tb_top;
  import hpk_pkg::*;

  localparam int unsigned LATENCY = 63;
  localparam logic signed [31:0] ONE  = 32'sh1000_0000;
  localparam logic signed [31:0] MAXF = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINF = 32'sh8000_0000;
  localparam logic [31:0] MOD_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] MOD_ONE = 32'h0001_0000;

  typedef logic [0:8][31:0] grad_t;  // xx xy xz yx yy yz zx zy zz
  typedef struct packed {
    logic [0:5][47:0] s;             // xx yy zz xy xz yz
    logic             sing;
    logic             sat;
  } stress_t;
  typedef struct packed {
    logic [1:0]  model;
    logic [31:0] lam;
    logic [31:0] shear;
    grad_t       grad;
    logic        typed;
    stress_t     res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  grad_t grad_r = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = REG_MODEL;
  logic [31:0] cfg_data_i = '0;
  logic done_o;
  logic signed [SW-1:0] s_xx_o, s_yy_o, s_zz_o, s_xy_o, s_xz_o, s_yz_o;
  logic singular_o, saturated_o;

  // bench copy of the configuration
  logic [1:0]  model_cfg = MODEL_LIN;
  logic [31:0] lam_cfg = MOD_ONE;
  logic [31:0] shear_cfg = MOD_ONE;

  // typed expectation for the item being driven
  logic    typed_r = 1'b0;
  stress_t typed_res_r = '0;

  stress_t stress_q[$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  dir_row_t dir_tab[$];

  hyperelastic_pk2_stress_core i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .f_xx_i(grad_r[0]), .f_xy_i(grad_r[1]), .f_xz_i(grad_r[2]),
    .f_yx_i(grad_r[3]), .f_yy_i(grad_r[4]), .f_yz_i(grad_r[5]),
    .f_zx_i(grad_r[6]), .f_zy_i(grad_r[7]), .f_zz_i(grad_r[8]),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .done_o, .s_xx_o, .s_yy_o, .s_zz_o, .s_xy_o, .s_xz_o, .s_yz_o,
    .singular_o, .saturated_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic signed [127:0] wmul(input longint a, input longint b);
    logic signed [127:0] x, y;
    x = a;
    y = b;
    return x * y;
  endfunction

  // round to nearest, ties up, full width
  function automatic logic signed [127:0] rnd_wide(input logic signed [127:0] a,
                                                    input int unsigned sh);
    logic signed [127:0] one;
    one = 128'sd1;
    return (a + (one <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint rnd64(input logic signed [127:0] a, input int unsigned sh);
    logic signed [127:0] t;
    t = rnd_wide(a, sh);
    return longint'(t[63:0]);
  endfunction

  // quotient rounded to nearest, ties away from zero
  function automatic logic signed [127:0] div_round(input logic signed [127:0] n,
                                                     input longint d);
    logic [127:0] m, ud, q;
    logic neg;
    longint ad;
    neg = (n < 0) != (d < 0);
    m = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    ud = {64'b0, ad};
    q = (2 * m + ud) / (2 * ud);
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [47:0] clip48(input logic signed [127:0] a, inout logic flag);
    if (a > 128'sd140737488355327) begin
      flag = 1'b1;
      return 48'h7FFF_FFFF_FFFF;
    end
    if (a < -128'sd140737488355328) begin
      flag = 1'b1;
      return 48'h8000_0000_0000;
    end
    return a[47:0];
  endfunction

  function automatic stress_t pk2_predict(input grad_t gr, input logic [1:0] model,
                                          input logic [31:0] lam_u,
                                          input logic [31:0] g_u);
    longint f[3][3], c[3][3], e[3][3];
    longint lam, g, tr, m0, m1, m2, jq, kq, d;
    longint adj[6];
    logic signed [127:0] s[6];
    logic signed [127:0] t, p, det, acc;
    int ri[6], ci[6];
    stress_t r;
    logic flag;
    ri = '{0, 1, 2, 0, 0, 1};
    ci = '{0, 1, 2, 1, 2, 2};
    lam = {32'b0, lam_u};
    g = {32'b0, g_u};
    r = '0;
    flag = 1'b0;
    for (int i = 0; i < 9; i++) f[i / 3][i % 3] = longint'($signed(gr[i]));
    for (int i = 0; i < 6; i++) s[i] = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = '0;
        for (int k = 0; k < 3; k++) acc = acc + wmul(f[k][i], f[k][j]);
        c[i][j] = rnd64(acc, 28);
      end
    end
    if (model == MODEL_LIN || model == MODEL_SVK) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          d = (i == j) ? 64'sd268435456 : 0;
          e[i][j] = (model == MODEL_LIN) ? f[i][j] + f[j][i] - 2 * d : c[i][j] - d;
        end
      end
      tr = e[0][0] + e[1][1] + e[2][2];
      t = wmul(lam, tr);
      for (int i = 0; i < 6; i++) begin
        p = wmul(g, e[ri[i]][ci[i]]);
        p = p + p;
        if (i < 3) p = p + t;
        s[i] = rnd_wide(p, 17);
      end
    end else if (model == MODEL_NEO) begin
      m0 = rnd64(wmul(f[1][1], f[2][2]) - wmul(f[1][2], f[2][1]), 28);
      m1 = rnd64(wmul(f[1][0], f[2][2]) - wmul(f[1][2], f[2][0]), 28);
      m2 = rnd64(wmul(f[1][0], f[2][1]) - wmul(f[1][1], f[2][0]), 28);
      det = wmul(f[0][0], m0) - wmul(f[0][1], m1) + wmul(f[0][2], m2);
      jq = rnd64(det, 28);
      if (jq == 0) begin
        r.sing = 1'b1;
      end else begin
        kq = rnd64(wmul(lam, jq - 64'sd268435456) - wmul(g, 64'sd268435456), 16);
        adj[0] = rnd64(wmul(c[1][1], c[2][2]) - wmul(c[1][2], c[1][2]), 28);
        adj[1] = rnd64(wmul(c[0][0], c[2][2]) - wmul(c[0][2], c[0][2]), 28);
        adj[2] = rnd64(wmul(c[0][0], c[1][1]) - wmul(c[0][1], c[0][1]), 28);
        adj[3] = rnd64(wmul(c[0][2], c[1][2]) - wmul(c[0][1], c[2][2]), 28);
        adj[4] = rnd64(wmul(c[0][1], c[1][2]) - wmul(c[0][2], c[1][1]), 28);
        adj[5] = rnd64(wmul(c[0][1], c[0][2]) - wmul(c[0][0], c[1][2]), 28);
        for (int i = 0; i < 6; i++) begin
          s[i] = div_round(wmul(kq, adj[i]), jq);
          if (i < 3) s[i] = s[i] + wmul(g, 64'sd4096);
        end
      end
    end
    for (int i = 0; i < 6; i++) r.s[i] = clip48(s[i], flag);
    r.sat = flag;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    n_errors++;
  endtask

  // record each accepted gradient, compare each result with the oldest expectation
  always @(posedge clk_i) begin
    stress_t want;
    logic [0:5][47:0] got;
    if (rst_ni && start_i && !busy_o) begin
      if (typed_r) stress_q.push_back(typed_res_r);
      else stress_q.push_back(pk2_predict(grad_r, model_cfg, lam_cfg, shear_cfg));
    end
    if (rst_ni && done_o) begin
      got = {s_xx_o, s_yy_o, s_zz_o, s_xy_o, s_xz_o, s_yz_o};
      if (stress_q.size() == 0) begin
        report_mismatch("unexpected result", got[0], '0);
      end else begin
        want = stress_q.pop_front();
        for (int i = 0; i < 6; i++)
          if (got[i] !== want.s[i]) report_mismatch($sformatf("stress[%0d]", i), got[i],
                                                    want.s[i]);
        if (singular_o !== want.sing) report_mismatch("singular", singular_o, want.sing);
        if (saturated_o !== want.sat) report_mismatch("saturated", saturated_o, want.sat);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  // stop driving, then wait for every result in flight
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (stress_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MODEL:  model_cfg = data[1:0];
      REG_LAMBDA: lam_cfg = data;
      REG_SHEAR:  shear_cfg = data;
      default: ;
    endcase
  endtask

  task automatic set_material(input logic [1:0] model, input logic [31:0] lam,
                              input logic [31:0] shear);
    if (model == model_cfg && lam == lam_cfg && shear == shear_cfg) return;
    drain();
    write_reg(REG_MODEL, {30'($urandom_range(0, 16383)), model});
    write_reg(REG_LAMBDA, lam);
    write_reg(REG_SHEAR, shear);
  endtask

  // drive one gradient; hold start high until the transfer
  task automatic send_grad(input grad_t gr, input logic typed, input stress_t res,
                           input logic may_idle);
    if (may_idle && $urandom_range(0, 99) < 6) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    grad_r <= gr;
    typed_r <= typed;
    typed_res_r <= res;
    do @(posedge clk_i); while (busy_o);
    n_sent++;
  endtask

  function automatic dir_row_t mk_row(input logic [1:0] model, input logic [31:0] lam,
                                      input logic [31:0] shear, input grad_t gr,
                                      input logic typed, input stress_t res);
    dir_row_t r;
    r.model = model;
    r.lam = lam;
    r.shear = shear;
    r.grad = gr;
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  function automatic logic signed [31:0] near(input logic signed [31:0] base);
    return base + $signed($urandom_range(0, 1 << 27)) - (1 << 26);
  endfunction

  function automatic grad_t rand_grad();
    grad_t gr;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 9; i++) begin
      if (kind < 60) gr[i] = near((i % 4 == 0) ? ONE : 32'sd0);
      else if (kind < 90) gr[i] = $urandom();
      else gr[i] = $urandom_range(0, 1) ? MAXF : MINF;
    end
    // copy a row now and then to reach the zero determinant
    if ($urandom_range(0, 19) == 0) begin
      gr[6] = gr[3];
      gr[7] = gr[4];
      gr[8] = gr[5];
    end
    return gr;
  endfunction

  function automatic logic [31:0] rand_modulus();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return MOD_MAX;
      2: return $urandom();
      default: return $urandom_range(0, 64) << 16 | $urandom_range(0, 65535);
    endcase
  endfunction

  initial begin
    grad_t ident, zero_g, max_g, min_g, alt_g, diag_min, diag_max;
    stress_t zero_res, sing_res, clip_res;
    logic [1:0] model;
    ident = {ONE, 32'sd0, 32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0, ONE};
    zero_g = '0;
    max_g = {9{MAXF}};
    min_g = {9{MINF}};
    alt_g = {MAXF, MINF, MAXF, MINF, MAXF, MINF, MAXF, MINF, MAXF};
    diag_min = {MINF, 32'sd0, 32'sd0, 32'sd0, MINF, 32'sd0, 32'sd0, 32'sd0, MINF};
    diag_max = {MAXF, 32'sd0, 32'sd0, 32'sd0, MAXF, 32'sd0, 32'sd0, 32'sd0, MAXF};
    zero_res = '0;
    sing_res = '0;
    sing_res.sing = 1'b1;
    clip_res.s = {6{48'h7FFF_FFFF_FFFF}};
    clip_res.sing = 1'b0;
    clip_res.sat = 1'b1;

    // directed rows: identity is stress free, singular and unused model read as zeros
    dir_tab.push_back(mk_row(MODEL_LIN, MOD_ONE, MOD_ONE, ident, 1'b1, zero_res));
    dir_tab.push_back(mk_row(MODEL_LIN, MOD_ONE, MOD_ONE, max_g, 1'b0, zero_res));
    dir_tab.push_back(mk_row(MODEL_LIN, MOD_MAX, MOD_MAX, min_g, 1'b0, zero_res));
    dir_tab.push_back(mk_row(MODEL_LIN, MOD_MAX, MOD_MAX, alt_g, 1'b0, zero_res));
    dir_tab.push_back(mk_row(MODEL_SVK, MOD_ONE, MOD_ONE, ident, 1'b1, zero_res));
    dir_tab.push_back(mk_row(MODEL_SVK, MOD_MAX, MOD_MAX, max_g, 1'b1, clip_res));
    dir_tab.push_back(mk_row(MODEL_SVK, MOD_MAX, MOD_MAX, diag_min, 1'b0, zero_res));
    dir_tab.push_back(mk_row(MODEL_SVK, '0, '0, alt_g, 1'b1, zero_res));
    dir_tab.push_back(mk_row(MODEL_NEO, MOD_ONE, MOD_ONE, ident, 1'b1, zero_res));
    dir_tab.push_back(mk_row(MODEL_NEO, MOD_ONE, MOD_ONE, zero_g, 1'b1, sing_res));
    dir_tab.push_back(mk_row(MODEL_NEO, MOD_ONE, MOD_ONE, max_g, 1'b1, sing_res));
    dir_tab.push_back(mk_row(MODEL_NEO, MOD_ONE, MOD_ONE, diag_min, 1'b0, zero_res));
    dir_tab.push_back(mk_row(MODEL_NEO, MOD_MAX, MOD_MAX, diag_max, 1'b0, zero_res));
    dir_tab.push_back(mk_row(MODEL_NEO, MOD_MAX, '0, diag_min, 1'b0, zero_res));
    dir_tab.push_back(mk_row(MODEL_NEO, '0, MOD_MAX, alt_g, 1'b0, zero_res));
    dir_tab.push_back(mk_row(MODEL_UNUSED, MOD_MAX, MOD_MAX, max_g, 1'b1, zero_res));
    dir_tab.push_back(mk_row(MODEL_UNUSED, MOD_ONE, MOD_ONE, min_g, 1'b1, zero_res));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out-of-range register index must leave the settings alone
    write_reg(REG_NONE, 32'hDEAD_BEEF);

    foreach (dir_tab[i]) begin
      set_material(dir_tab[i].model, dir_tab[i].lam, dir_tab[i].shear);
      send_grad(dir_tab[i].grad, dir_tab[i].typed, dir_tab[i].res, 1'b0);
    end
    start_i <= 1'b0;

    // random phases, each with its own setting; the middle runs without idling
    for (int ph = 0; ph < 8; ph++) begin
      model = (ph % 4 == 3) ? MODEL_UNUSED : 2'(ph % 3);
      if (ph == 7) model = MODEL_NEO;
      drain();
      write_reg(REG_MODEL, {30'($urandom_range(0, 16383)), model});
      write_reg(REG_LAMBDA, (ph == 1) ? MOD_MAX : rand_modulus());
      write_reg(REG_SHEAR, (ph == 2) ? '0 : rand_modulus());
      if ($urandom_range(0, 1)) write_reg(REG_NONE, $urandom());
      for (int k = 0; k < 130; k++)
        send_grad(rand_grad(), 1'b0, zero_res, !(n_sent > 400 && n_sent < 700));
      start_i <= 1'b0;
    end

    while (stress_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
